// ===== src/assert_macros.svh =====
// Assertion macros shared by the max-tracking stack RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property checked on every rising edge outside reset.
`define MSU_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define MSU_NEVER(label, clk, rst, cond, msg) \
  `MSU_ASSERT(label, clk, rst, !(cond), msg)

`endif

// ===== src/msu_pkg.sv =====
// Package of the max-tracking stack: sizes, opcode and status codes, FSM type.
// Depends on nothing; used by the top level.
package msu_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int DEPTH_W     = 11;
  localparam int S_TDATA_W   = 32;
  localparam int M_FIELDS_W  = DATA_W + 1 + DEPTH_W;
  localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_QUERY = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DONE = 2'b10
  } state_t;

endpackage

// ===== src/msu_ram.sv =====
// Simple dual-port synchronous RAM, one write and one read port, registered read data.
// Depends on nothing; instantiated twice by the top level for the two stacks.
module msu_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/max_tracking_stack_unit.sv =====
// Stack of signed 32-bit values that reports its maximum with every request.
// A request is push, pop or query; each gives exactly one result holding the
// current maximum (zero and max_valid low when empty), the depth and a status:
// overflow for a push onto a full stack, underflow for a pop from an empty one,
// both leaving the stack untouched. In the idle state a request is accepted,
// the counts update and the value and maxima RAMs are written or read; in the
// done state the registered RAM read data (the new tops after a pop) is folded
// in and the result loaded into the output register. The done state is held
// for as long as the output register still holds a result that has not been
// taken. The next request is taken in the cycle after the load, even while the
// previous result still waits on the master side. The RAMs need no clearing
// pass after reset.
`include "assert_macros.svh"

module max_tracking_stack_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [msu_pkg::S_TDATA_W-1:0] s_tdata,   // [31:0] push_value
  input  logic [1:0]                    s_tuser,   // [1:0] opcode
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [31:0] max_value, [32] max_valid, [43:33] depth, rest zero
  output logic [msu_pkg::M_TDATA_W-1:0] m_tdata,
  output logic [1:0]                    m_tuser    // [1:0] status
);
  import msu_pkg::*;

  state_t                    state;
  logic [CNT_W-1:0]          value_count;
  logic [CNT_W-1:0]          maxima_count;
  logic signed [DATA_W-1:0]  top_value;
  logic signed [DATA_W-1:0]  top_max;
  logic                      val_rd;
  logic                      max_rd;
  status_t                   status_q;

  logic                      accept;
  opcode_t                   op;
  logic signed [DATA_W-1:0]  push_value;
  logic                      push_ok;
  logic                      pop_ok;
  logic                      max_push;
  logic                      max_pop;
  status_t                   status_next;
  logic [DATA_W-1:0]         val_rdata;
  logic [DATA_W-1:0]         max_rdata;
  logic signed [DATA_W-1:0]  top_value_eff;
  logic signed [DATA_W-1:0]  top_max_eff;
  logic                      out_free;
  logic                      load_out;
  logic                      res_valid;

  logic signed [DATA_W-1:0]  out_max_value;
  logic                      out_max_valid;
  logic [DEPTH_W-1:0]        out_depth;
  status_t                   out_status;

  assign s_tready   = (state == ST_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign op         = opcode_t'(s_tuser);
  assign push_value = $signed(s_tdata[DATA_W-1:0]);

  // Decode the request against the value count.
  always_comb begin
    push_ok     = 1'b0;
    pop_ok      = 1'b0;
    status_next = STATUS_OK;
    unique case (op)
      OP_PUSH: begin
        if (value_count == CNT_W'(STACK_DEPTH)) begin
          status_next = STATUS_OVERFLOW;
        end else begin
          push_ok = 1'b1;
        end
      end
      OP_POP: begin
        if (value_count == '0) begin
          status_next = STATUS_UNDERFLOW;
        end else begin
          pop_ok = 1'b1;
        end
      end
      default: begin
        status_next = STATUS_OK;
      end
    endcase
  end

  // A push joins the maxima stack when it is at least the current maximum.
  assign max_push = push_ok && (maxima_count != CNT_W'(STACK_DEPTH)) &&
                    ((maxima_count == '0) || (push_value >= top_max));
  // A pop leaves the maxima stack when the popped value is its top.
  assign max_pop  = pop_ok && (maxima_count != '0) && (top_max == top_value);

  // Value stack storage; after a pop the entry below the old top is read back.
  msu_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (DATA_W)
  ) u_value_ram (
    .clk     (clk),
    .wr_en   (accept && push_ok),
    .wr_addr (value_count[ADDR_W-1:0]),
    .wr_data (s_tdata[DATA_W-1:0]),
    .rd_en   (accept && pop_ok),
    .rd_addr (ADDR_W'(value_count - CNT_W'(2))),
    .rd_data (val_rdata)
  );

  // Maxima stack storage, same access pattern.
  msu_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (DATA_W)
  ) u_maxima_ram (
    .clk     (clk),
    .wr_en   (accept && max_push),
    .wr_addr (maxima_count[ADDR_W-1:0]),
    .wr_data (s_tdata[DATA_W-1:0]),
    .rd_en   (accept && max_pop),
    .rd_addr (ADDR_W'(maxima_count - CNT_W'(2))),
    .rd_data (max_rdata)
  );

  // Tops as seen when the result is loaded: fresh RAM data where a pop asked for it.
  assign top_value_eff = val_rd ? $signed(val_rdata) : top_value;
  assign top_max_eff   = max_rd ? $signed(max_rdata) : top_max;

  assign out_free  = !m_tvalid || m_tready;
  assign load_out  = (state == ST_DONE) && out_free;
  assign res_valid = (value_count != '0) && (maxima_count != '0);

  // Sequencer and stack counts.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      value_count  <= '0;
      maxima_count <= '0;
      val_rd       <= 1'b0;
      max_rd       <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_DONE;
            if (push_ok) begin
              value_count <= value_count + CNT_W'(1);
            end
            if (max_push) begin
              maxima_count <= maxima_count + CNT_W'(1);
            end
            if (pop_ok) begin
              value_count <= value_count - CNT_W'(1);
              val_rd      <= 1'b1;
            end
            if (max_pop) begin
              maxima_count <= maxima_count - CNT_W'(1);
              max_rd       <= 1'b1;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state  <= ST_IDLE;
            val_rd <= 1'b0;
            max_rd <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Cached tops of both stacks and the pending status.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_q <= status_next;
      if (push_ok) begin
        top_value <= push_value;
      end
      if (max_push) begin
        top_max <= push_value;
      end
    end else if (load_out) begin
      top_value <= top_value_eff;
      top_max   <= top_max_eff;
    end
  end

  // Output register handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_max_value <= res_valid ? top_max_eff : '0;
      out_max_valid <= res_valid;
      out_depth     <= DEPTH_W'(value_count);
      out_status    <= status_q;
    end
  end

  assign m_tdata = {{(M_TDATA_W - M_FIELDS_W){1'b0}}, out_depth, out_max_valid,
                    out_max_value};
  assign m_tuser = out_status;

  // The maxima stack never outgrows the value stack.
  `MSU_ASSERT(a_maxima_le_values, clk, rst, maxima_count <= value_count,
              "maxima stack deeper than value stack")
  // A non-empty value stack always has a maximum on record.
  `MSU_NEVER(a_max_present, clk, rst, (value_count != '0) && (maxima_count == '0),
             "values stacked but no maximum")
  // The count never passes the capacity.
  `MSU_ASSERT(a_count_bound, clk, rst, value_count <= CNT_W'(STACK_DEPTH),
              "value count beyond capacity")
  // A pop on a non-empty stack takes exactly one value off.
  `MSU_ASSERT(a_pop_count, clk, rst,
              accept && pop_ok |=> value_count == $past(value_count) - CNT_W'(1),
              "pop did not decrement count")

endmodule

// ===== tb/tb_max_tracking_stack_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for max_tracking_stack_unit: push, pop and query requests
// are checked against an in-bench stack model. Depends on msu_pkg and the unit's RTL.
module tb_max_tracking_stack_unit;
  import msu_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] value;
  } stack_request_t;

  typedef struct {
    logic [31:0]     max_value;
    logic            max_valid;
    logic [10:0]     depth;
    status_t         status;
  } max_report_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [1:0]           s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [1:0]           m_tuser;

  // Requests waiting to be sent and reports owed by the unit.
  stack_request_t requests_to_send[$];
  max_report_t    max_reports_due[$];

  // Shadow stack of values and of running maxima.
  logic [31:0] shadow_values[STACK_DEPTH];
  logic [31:0] shadow_maxima[STACK_DEPTH];
  int          shadow_count = 0;
  int          maxima_count = 0;

  int mismatch_count = 0;
  int push_total = 0, pop_total = 0, query_total = 0;
  int overflow_total = 0, underflow_total = 0, deepest = 0;

  max_tracking_stack_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Applies one request to the shadow stack and returns the report it should give.
  function automatic max_report_t apply_stack_request(logic [1:0] op, logic [31:0] value);
    max_report_t r;
    r.status = STATUS_OK;
    if (op == OP_PUSH) begin
      push_total++;
      if (shadow_count >= STACK_DEPTH) begin
        r.status = STATUS_OVERFLOW;
        overflow_total++;
      end else begin
        shadow_values[shadow_count] = value;
        shadow_count++;
        if (maxima_count == 0 ||
            $signed(value) >= $signed(shadow_maxima[maxima_count-1])) begin
          if (maxima_count < STACK_DEPTH) begin
            shadow_maxima[maxima_count] = value;
            maxima_count++;
          end
        end
      end
    end else if (op == OP_POP) begin
      pop_total++;
      if (shadow_count == 0) begin
        r.status = STATUS_UNDERFLOW;
        underflow_total++;
      end else begin
        shadow_count--;
        if (maxima_count > 0 &&
            shadow_maxima[maxima_count-1] == shadow_values[shadow_count])
          maxima_count--;
      end
    end else begin
      query_total++;
    end
    if (shadow_count > deepest) deepest = shadow_count;
    if (shadow_count > 0 && maxima_count > 0) begin
      r.max_value = shadow_maxima[maxima_count-1];
      r.max_valid = 1'b1;
    end else begin
      r.max_value = '0;
      r.max_valid = 1'b0;
    end
    r.depth = shadow_count[10:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic queue_request(logic [1:0] op, logic [31:0] value);
    stack_request_t req;
    req.op = op;
    req.value = value;
    requests_to_send.push_back(req);
  endtask

  // Push values: full range, a narrow band for repeated maxima, and the extremes.
  function automatic logic [31:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return $urandom;
    if (sel < 8) return $unsigned($signed($urandom_range(0, 8)) - 4);
    if (sel == 8) return 32'h7FFF_FFFF;
    return 32'h8000_0000;
  endfunction

  // Random operation with the given weights in percent for push and pop.
  function automatic logic [1:0] pick_op(int unsigned push_pct, int unsigned pop_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) return OP_PUSH;
    if (roll < push_pct + pop_pct) return OP_POP;
    if (roll < 95) return OP_QUERY;
    return OP_UNUSED;
  endfunction

  task automatic wait_until_drained();
    do @(posedge clk);
    while (requests_to_send.size() != 0 || s_tvalid || max_reports_due.size() != 0);
  endtask

  // Sender: bursts of requests with random gaps between them.
  int burst_left;
  int gap_left;
  always @(posedge clk) begin : drive_requests
    stack_request_t req;
    logic offer;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= '0;
      burst_left = 8;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready)
        max_reports_due.push_back(apply_stack_request(s_tuser, s_tdata));
      if (!s_tvalid || s_tready) begin
        offer = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (requests_to_send.size() > 0) begin
          req = requests_to_send.pop_front();
          offer = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
          end
        end
        s_tvalid <= offer;
        if (offer) begin
          s_tdata <= req.value;
          s_tuser <= req.op;
        end
      end
    end
  end

  // Receiver: checks each result; its stall mode is redrawn at random, from always ready to heavy stalling.
  int stall_mode;
  int stall_tick;
  always @(posedge clk) begin : check_reports
    max_report_t want;
    logic ready_next;
    if (rst) begin
      m_tready <= 1'b0;
      stall_mode = 0;
      stall_tick = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (max_reports_due.size() == 0) begin
          report_mismatch("result with no request outstanding", m_tdata[31:0], '0);
        end else begin
          want = max_reports_due.pop_front();
          if (m_tdata[31:0] !== want.max_value)
            report_mismatch("max_value", m_tdata[31:0], want.max_value);
          if (m_tdata[32] !== want.max_valid)
            report_mismatch("max_valid", 32'(m_tdata[32]), 32'(want.max_valid));
          if (m_tdata[43:33] !== want.depth)
            report_mismatch("depth", 32'(m_tdata[43:33]), 32'(want.depth));
          if (m_tuser !== want.status)
            report_mismatch("status", 32'(m_tuser), 32'(want.status));
        end
      end
      stall_tick++;
      if (stall_tick % 50 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        2: begin
          ready_next = ($urandom_range(0, 9) < 7);
        end
        3: begin
          ready_next = (stall_tick % 4 == 0);
        end
        default: begin
          ready_next = 1'b1;
        end
      endcase
      m_tready <= ready_next;
    end
  end

  // Stimulus: directed corner cases, then mixed traffic, a fill to full and a
  // pop-heavy tail, each phase draining completely before the next.
  initial begin : stimulus
    int to_fill;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Empty stack, extremes, repeated maxima and the unused opcode.
    queue_request(OP_POP, 32'hFFFF_FFFF);
    queue_request(OP_QUERY, 32'h0);
    queue_request(OP_UNUSED, 32'hFFFF_FFFF);
    queue_request(OP_PUSH, 32'h7FFF_FFFF);
    queue_request(OP_PUSH, 32'h8000_0000);
    queue_request(OP_QUERY, 32'hFFFF_FFFF);
    queue_request(OP_POP, 32'h0);
    queue_request(OP_PUSH, 32'h7FFF_FFFF);
    queue_request(OP_POP, 32'h0);
    queue_request(OP_QUERY, 32'h0);
    queue_request(OP_POP, 32'h0);
    queue_request(OP_POP, 32'h0);
    queue_request(OP_PUSH, -32'sd5);
    queue_request(OP_PUSH, -32'sd7);
    queue_request(OP_PUSH, -32'sd5);
    queue_request(OP_PUSH, 32'd3);
    queue_request(OP_UNUSED, 32'hFFFF_FFFF);
    queue_request(OP_POP, 32'h0);
    queue_request(OP_POP, 32'h0);
    queue_request(OP_POP, 32'h0);
    queue_request(OP_POP, 32'h0);
    queue_request(OP_PUSH, 32'h0);
    queue_request(OP_PUSH, 32'hFFFF_FFFF);
    queue_request(OP_POP, 32'h0);
    queue_request(OP_POP, 32'h0);
    wait_until_drained();

    // Mixed traffic around small depths, underflow included.
    repeat (250) queue_request(pick_op(45, 35), pick_value());
    wait_until_drained();

    // Fill to the top with some queries, then push against the full stack.
    to_fill = STACK_DEPTH - shadow_count;
    while (to_fill > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_request(OP_QUERY, $urandom);
      end else begin
        queue_request(OP_PUSH, pick_value());
        to_fill--;
      end
    end
    repeat (4) queue_request(OP_PUSH, pick_value());
    queue_request(OP_QUERY, $urandom);
    wait_until_drained();

    // Pop-heavy tail from the full stack.
    repeat (500) queue_request(pick_op(30, 55), pick_value());
    wait_until_drained();

    repeat (20) @(posedge clk);
    $display("Covered %0d pushes (%0d overflowed), %0d pops (%0d underflowed), %0d queries.",
             push_total, overflow_total, pop_total, underflow_total, query_total);
    $display("Deepest stack reached: %0d entries.", deepest);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
